// ===== rtl/ilt_pkg.sv =====
// ----------------------------------------------------------------------------
// ilt_pkg: shared definitions for the indexed list table.
// Holds the list geometry, request and status codes, the controller state
// type and the command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ilt_pkg;

   // List geometry.
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int POS_W    = 5;
   localparam int COUNT_W  = 5;
   localparam int DATA_W   = 32;
   localparam int TYPE_W   = 3;
   localparam int STAT_W   = 2;

   // Request codes.
   localparam logic [TYPE_W-1:0] REQ_INS_HEAD = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_INS_END  = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_INS_AT   = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_GET      = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_DELETE   = 3'd4;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPLY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture the request fields
      logic exec;   // apply the request to the list and capture the reply
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/ilt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilt_ctrl: request sequencer for the indexed list table.
// Steps each request through capture, execution and the reply strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module ilt_ctrl
   import ilt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output cmd_type      cmd,
   output logic         busy,
   output logic         rsp_valid
);

   state_type state_ff;
   state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs decoded from the state.
   always_comb begin
      cmd.load  = 1'b0;
      cmd.exec  = 1'b0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_REPLY: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/ilt_datapath.sv =====
// ----------------------------------------------------------------------------
// ilt_datapath: entry registers, count and reply registers.
// Every entry register can take its neighbor's value, so an insert or a
// delete shifts the entries behind its position in the execute state.
// ----------------------------------------------------------------------------
`default_nettype none

module ilt_datapath
   import ilt_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   input  wire logic [TYPE_W-1:0]         req_type,
   input  wire logic [POS_W-1:0]          req_position,
   input  wire logic signed [DATA_W-1:0]  req_item_value,
   output logic signed [DATA_W-1:0]       rsp_read_value,
   output logic [STAT_W-1:0]              rsp_status,
   output logic [COUNT_W-1:0]             rsp_list_count
);

   logic [TYPE_W-1:0]         type_ff;
   logic [POS_W-1:0]          pos_ff;
   logic signed [DATA_W-1:0]  value_ff;

   logic signed [DATA_W-1:0]  store_ff [CAPACITY];
   logic signed [DATA_W-1:0]  store_in [CAPACITY];
   logic [COUNT_W-1:0]        count_ff;
   logic [COUNT_W-1:0]        count_in;

   logic signed [DATA_W-1:0]  read_ff;
   logic signed [DATA_W-1:0]  read_in;
   logic [STAT_W-1:0]         stat_ff;
   logic [STAT_W-1:0]         stat_in;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff  <= req_type;
         pos_ff   <= req_position;
         value_ff <= req_item_value;
      end
   end

   // Request execution: range checks, shifts and the reply fields.
   always_comb begin
      logic [POS_W-1:0] ins_pos;
      logic             do_ins;
      logic             pos_ok;

      store_in = store_ff;
      count_in = count_ff;
      read_in  = '0;
      stat_in  = STAT_DONE;
      ins_pos  = '0;
      do_ins   = 1'b0;
      pos_ok   = (pos_ff < count_ff);

      case (type_ff)
         REQ_INS_HEAD: begin
            ins_pos = '0;
            do_ins  = 1'b1;
         end
         REQ_INS_END: begin
            ins_pos = count_ff;
            do_ins  = 1'b1;
         end
         REQ_INS_AT: begin
            ins_pos = pos_ff;
            do_ins  = 1'b1;
         end
         REQ_GET: begin
            if (pos_ok) begin
               read_in = store_ff[pos_ff[IDX_W-1:0]];
            end else begin
               read_in = '1;
               stat_in = STAT_RANGE;
            end
         end
         REQ_DELETE: begin
            if (pos_ok) begin
               // Entries behind the deleted one move down one place.
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (POS_W'(i) >= pos_ff) begin
                     store_in[i] = store_ff[i + 1];
                  end
               end
               count_in = count_ff - COUNT_W'(1);
            end else begin
               stat_in = STAT_RANGE;
            end
         end
         default: begin
            stat_in = STAT_DONE;
         end
      endcase

      // Insert: the range check comes before the full check.
      if (do_ins) begin
         if (ins_pos > count_ff) begin
            stat_in = STAT_RANGE;
         end else if (count_ff >= COUNT_W'(CAPACITY)) begin
            stat_in = STAT_FULL;
         end else begin
            for (int i = 1; i < CAPACITY; i++) begin
               if (POS_W'(i) > ins_pos) begin
                  store_in[i] = store_ff[i - 1];
               end
            end
            for (int i = 0; i < CAPACITY; i++) begin
               if (POS_W'(i) == ins_pos) begin
                  store_in[i] = value_ff;
               end
            end
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   // Entry registers.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         store_ff <= store_in;
      end
   end

   // Entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   // Reply registers.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         read_ff <= read_in;
         stat_ff <= stat_in;
      end
   end

   assign rsp_read_value = read_ff;
   assign rsp_status     = stat_ff;
   assign rsp_list_count = count_ff;

endmodule

`default_nettype wire

// ===== rtl/indexed_list_table.sv =====
// ----------------------------------------------------------------------------
// indexed_list_table: ordered list of up to sixteen signed 32-bit values.
// Inserts at head, end or a position, reads or deletes at a position, and
// returns the value read, a status and the entry count for every request.
//
//   Channel   Ports                                       Handshake
//   request   req_type, req_position, req_item_value      start and not busy
//   reply     rsp_read_value, rsp_status, rsp_list_count  rsp_valid, one cycle
//
// A request goes through capture, execute and reply. Insert and delete
// shift the entry registers behind the position in the execute state;
// busy is low again in the cycle after the reply strobe. Reset is
// synchronous and empties the list at once. The receiver cannot stall:
// each reply is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_table
   import ilt_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic [TYPE_W-1:0]         req_type,
   input  wire logic [POS_W-1:0]          req_position,
   input  wire logic signed [DATA_W-1:0]  req_item_value,
   output logic                           rsp_valid,
   output logic signed [DATA_W-1:0]       rsp_read_value,
   output logic [STAT_W-1:0]              rsp_status,
   output logic [COUNT_W-1:0]             rsp_list_count
);

   cmd_type cmd;

   // Request sequencer.
   ilt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // List storage and reply datapath.
   ilt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_list_count (rsp_list_count)
   );

endmodule

`default_nettype wire

// ===== test/ilt_checker.sv =====
// ----------------------------------------------------------------------------
// ilt_checker: reply checker for the indexed list table.
// Watches the request and reply channels, keeps a shadow copy of the list,
// works out the reply for every accepted request and compares each reply
// field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module ilt_checker
   import ilt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic [TYPE_W-1:0]         req_type,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [DATA_W-1:0]  req_item_value,
   input  logic                      rsp_valid,
   input  logic signed [DATA_W-1:0]  rsp_read_value,
   input  logic [STAT_W-1:0]         rsp_status,
   input  logic [COUNT_W-1:0]        rsp_list_count,
   output int                        fail_count,
   output int                        pending,
   output int                        reply_count,
   output int                        full_count,
   output int                        range_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [STAT_W-1:0]        status;
      logic [COUNT_W-1:0]       list_count;
   } reply_type;

   // Shadow copy of the list and the replies still owed by the block.
   logic signed [DATA_W-1:0] shadow_list [CAPACITY];
   int                       shadow_len = 0;
   reply_type                expected_replies [$];

   initial begin
      fail_count  = 0;
      pending     = 0;
      reply_count = 0;
      full_count  = 0;
      range_count = 0;
   end

   // Apply one request to the shadow list and return the reply it should give.
   function automatic reply_type apply_request(logic [TYPE_W-1:0] kind,
                                               logic [POS_W-1:0] pos,
                                               logic signed [DATA_W-1:0] value);
      reply_type r;
      int        target;
      r.read_value = '0;
      r.status     = STAT_DONE;
      target       = int'(pos);
      case (kind)
         REQ_INS_HEAD, REQ_INS_END, REQ_INS_AT: begin
            if (kind == REQ_INS_HEAD)
               target = 0;
            else if (kind == REQ_INS_END)
               target = shadow_len;
            // The range check comes before the full check.
            if (target > shadow_len) begin
               r.status = STAT_RANGE;
            end else if (shadow_len >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               for (int i = shadow_len; i > target; i--)
                  shadow_list[i] = shadow_list[i-1];
               shadow_list[target] = value;
               shadow_len++;
            end
         end
         REQ_GET: begin
            if (target < shadow_len) begin
               r.read_value = shadow_list[target];
            end else begin
               r.read_value = -1;
               r.status     = STAT_RANGE;
            end
         end
         REQ_DELETE: begin
            if (target < shadow_len) begin
               for (int i = target; i + 1 < shadow_len; i++)
                  shadow_list[i] = shadow_list[i+1];
               shadow_len--;
            end else begin
               r.status = STAT_RANGE;
            end
         end
         default: ;
      endcase
      r.list_count = COUNT_W'(shadow_len);
      return r;
   endfunction

   // Print one line per mismatch and count it.
   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t ns: reply mismatch on %s: got %0d, expected %0d",
               $time, what, got, want);
      fail_count++;
   endtask

   // Compare replies first, then record the request accepted at this edge.
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         shadow_len = 0;
         expected_replies.delete();
      end else begin
         if (rsp_valid) begin
            reply_count++;
            if (expected_replies.size() == 0) begin
               report_mismatch("reply with no request waiting", 1, 0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_read_value !== want.read_value)
                  report_mismatch("read_value", rsp_read_value, want.read_value);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_list_count !== want.list_count)
                  report_mismatch("list_count", rsp_list_count, want.list_count);
            end
         end
         if (start && !busy) begin
            want = apply_request(req_type, req_position, req_item_value);
            if (want.status == STAT_FULL)
               full_count++;
            if (want.status == STAT_RANGE)
               range_count++;
            expected_replies.push_back(want);
         end
      end
      pending = expected_replies.size();
   end

endmodule

// ===== test/tb_indexed_list_table.sv =====
// ----------------------------------------------------------------------------
// tb_indexed_list_table: testbench for the indexed list table.
// Drives a directed opening (empty list, full list, out-of-range positions,
// unknown request types, extreme values) followed by random growing and
// shrinking sequences under several sender pacing phases. A checker beside
// the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_indexed_list_table;
   import ilt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 1000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [TYPE_W-1:0]         req_type = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [DATA_W-1:0]  req_item_value = '0;
   logic                      rsp_valid;
   logic signed [DATA_W-1:0]  rsp_read_value;
   logic [STAT_W-1:0]         rsp_status;
   logic [COUNT_W-1:0]        rsp_list_count;

   int fail_count;
   int pending;
   int reply_count;
   int full_count;
   int range_count;
   int requests_sent = 0;
   int idle_cycles   = 0;
   int sender_idle_pct = 0;

   indexed_list_table uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_list_count (rsp_list_count)
   );

   ilt_checker reply_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_list_count (rsp_list_count),
      .fail_count     (fail_count),
      .pending        (pending),
      .reply_count    (reply_count),
      .full_count     (full_count),
      .range_count    (range_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: ends the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Present one request, after an optional idle gap, and hold it until taken.
   task automatic issue_request(logic [TYPE_W-1:0] kind, int pos,
                                logic signed [DATA_W-1:0] value);
      int gap;
      gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= kind;
      req_position   <= POS_W'(pos);
      req_item_value <= value;
      do @(posedge clock); while (busy);
      requests_sent++;
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return -1;
            default: return 0;
         endcase
      end
      return $urandom();
   endfunction

   // Random requests in stretches that each grow or shrink at random, so the
   // list often runs both empty and full.
   task automatic random_requests(int n, int idle_pct);
      int                draw;
      int                pos;
      logic [TYPE_W-1:0] kind;
      bit                growing;
      sender_idle_pct = idle_pct;
      growing = 1'b1;
      for (int i = 0; i < n; i++) begin
         if (i % 40 == 0)
            growing = 1'($urandom_range(1));
         draw = $urandom_range(99);
         if (draw < 3)
            kind = TYPE_W'($urandom_range(5, 7));
         else if (draw < (growing ? 55 : 25))
            kind = TYPE_W'($urandom_range(REQ_INS_HEAD, REQ_INS_AT));
         else if (draw < (growing ? 75 : 45))
            kind = REQ_GET;
         else
            kind = REQ_DELETE;
         pos = ($urandom_range(99) < 10) ? $urandom_range(0, 31) : $urandom_range(0, 17);
         issue_request(kind, pos, pick_value());
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: empty list, bad positions and unknown types.
      sender_idle_pct = 0;
      issue_request(REQ_GET, 0, 0);
      issue_request(REQ_DELETE, 0, 0);
      issue_request(REQ_INS_AT, 1, 7);
      issue_request(REQ_INS_AT, 0, 32'sh7fff_ffff);
      issue_request(REQ_INS_HEAD, 0, 32'sh8000_0000);
      issue_request(REQ_INS_END, 31, -1);
      issue_request(REQ_INS_AT, 3, 0);
      issue_request(REQ_GET, 0, 0);
      issue_request(REQ_GET, 3, 0);
      issue_request(REQ_GET, 31, 0);
      issue_request(REQ_DELETE, 4, 0);
      issue_request(3'd5, 0, 0);
      issue_request(3'd6, 31, -1);
      issue_request(3'd7, 15, 32'sh7fff_ffff);

      // Fill the list to capacity, then insert while full.
      for (int i = 0; i < CAPACITY - 4; i++)
         issue_request((i % 2) ? REQ_INS_HEAD : REQ_INS_AT, i % 3, $urandom());
      issue_request(REQ_INS_HEAD, 0, 1);
      issue_request(REQ_INS_AT, 31, 2);
      issue_request(REQ_INS_AT, 5, 3);
      issue_request(REQ_INS_END, 0, 4);
      issue_request(REQ_GET, CAPACITY - 1, 0);
      issue_request(REQ_DELETE, CAPACITY - 1, 0);
      issue_request(REQ_DELETE, 0, 0);

      // Random part across sender pacing phases.
      random_requests(250, 0);
      random_requests(250, 69);
      random_requests(250, 17);
      random_requests(175, 0);
      start <= 1'b0;

      // Drain the outstanding replies, then allow the pipeline to settle.
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (5) @(posedge clock);

      $display("Ran %0d requests under four pacing phases; %0d replies checked.",
               requests_sent, reply_count);
      $display("Inserts refused while full: %0d, out-of-range positions: %0d.",
               full_count, range_count);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== indexed_list_table.f =====
rtl/ilt_pkg.sv
rtl/ilt_ctrl.sv
rtl/ilt_datapath.sv
rtl/indexed_list_table.sv
test/ilt_checker.sv
test/tb_indexed_list_table.sv
